// File: design/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg: shared types and constants for the integer stack machine
// Holds the word formats of both channels, opcode and mode codes, the
// stack geometry and the control structs passed between the sequencer,
// the stack memory and the arithmetic unit.
// ----------------------------------------------------------------------------
package ism_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Field widths
    localparam int VALUE_W   = 31;
    localparam int OPERAND_W = 30;
    localparam int ITER_W    = $clog2(OPERAND_W);

    // Magnitude limit of every stack value
    localparam logic [OPERAND_W-1:0] LIMIT_U      = 30'd1000000000;
    localparam logic signed [32:0]   LIMIT_S33    = 33'sd1000000000;
    localparam logic signed [32:0]   NEG_LIMIT_S33 = -33'sd1000000000;
    localparam logic signed [61:0]   LIMIT_S62    = 62'sd1000000000;
    localparam logic signed [61:0]   NEG_LIMIT_S62 = -62'sd1000000000;

    // Mode codes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_EXEC   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    // Opcodes
    localparam logic [3:0] OP_NUM = 4'd0;
    localparam logic [3:0] OP_POP = 4'd1;
    localparam logic [3:0] OP_INV = 4'd2;
    localparam logic [3:0] OP_DUP = 4'd3;
    localparam logic [3:0] OP_SWP = 4'd4;
    localparam logic [3:0] OP_ADD = 4'd5;
    localparam logic [3:0] OP_SUB = 4'd6;
    localparam logic [3:0] OP_MUL = 4'd7;
    localparam logic [3:0] OP_DIV = 4'd8;
    localparam logic [3:0] OP_MOD = 4'd9;

    // Arithmetic unit operations
    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_NEG,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD
    } alu_op_t;

    // Input word
    typedef struct packed {
        logic [1:0]           mode;
        logic [3:0]           opcode;
        logic [OPERAND_W-1:0] operand;
    } ism_in_t;

    // Result word
    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic                      status;
    } ism_out_t;

    // Request to the arithmetic unit: a is the second value, b the top
    typedef struct packed {
        logic                      start;
        alu_op_t                   op;
        logic signed [VALUE_W-1:0] a;
        logic signed [VALUE_W-1:0] b;
    } alu_req_t;

    // Response from the arithmetic unit
    typedef struct packed {
        logic                      done;
        logic                      err;
        logic signed [VALUE_W-1:0] result;
    } alu_rsp_t;

    // Stack memory write port
    typedef struct packed {
        logic                      en;
        logic [ADDR_W-1:0]         addr;
        logic signed [VALUE_W-1:0] data;
    } ram_wr_t;

endpackage

// File: design/ism_stack.sv
// ----------------------------------------------------------------------------
// ism_stack: value stack storage
// Single-port-write, single-port-read memory with a registered read.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module ism_stack (
    input  logic                               aclk,
    input  ism_pkg::ram_wr_t                   wr,
    input  logic                               rd_en,
    input  logic [ism_pkg::ADDR_W-1:0]         rd_addr,
    output logic signed [ism_pkg::VALUE_W-1:0] rd_data
);

    logic signed [ism_pkg::VALUE_W-1:0] mem [ism_pkg::STACK_DEPTH];
    logic signed [ism_pkg::VALUE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/ism_alu.sv
// ----------------------------------------------------------------------------
// ism_alu: shared arithmetic unit
// One 33-bit adder serves add, subtract, negate, the trial subtraction of
// a restoring divider (one quotient bit per cycle) and the final sign fix.
// A 31x31 multiplier feeds a registered range check.
// ----------------------------------------------------------------------------
module ism_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  ism_pkg::alu_req_t req,
    output ism_pkg::alu_rsp_t rsp
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_ADD,
        A_MUL,
        A_MUL_CHK,
        A_DIV_INIT,
        A_DIV,
        A_DIV_SIGN,
        A_DONE
    } alu_state_t;

    alu_state_t                         st_reg, st_next;
    ism_pkg::alu_op_t                   op_reg, op_next;
    logic signed [ism_pkg::VALUE_W-1:0] a_reg, a_next;
    logic signed [ism_pkg::VALUE_W-1:0] b_reg, b_next;
    logic signed [61:0]                 prod_reg, prod_next;
    logic [ism_pkg::OPERAND_W-1:0]      rem_reg, rem_next;
    logic [ism_pkg::OPERAND_W-1:0]      quo_reg, quo_next;
    logic [ism_pkg::OPERAND_W-1:0]      dvs_reg, dvs_next;
    logic [ism_pkg::ITER_W-1:0]         iter_reg, iter_next;
    logic signed [ism_pkg::VALUE_W-1:0] res_reg, res_next;
    logic                               err_reg, err_next;

    // Shared adder
    logic signed [32:0] add_x, add_y, add_sum;
    logic               add_sub;

    logic [ism_pkg::VALUE_W-1:0]   a_abs, b_abs;
    logic [ism_pkg::OPERAND_W-1:0] div_sel;
    logic                          div_neg;

    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {32'd0, add_sub};

    assign a_abs = a_reg[ism_pkg::VALUE_W-1] ? ism_pkg::VALUE_W'(-a_reg) : a_reg;
    assign b_abs = b_reg[ism_pkg::VALUE_W-1] ? ism_pkg::VALUE_W'(-b_reg) : b_reg;

    // Pick quotient or remainder and its sign
    always_comb begin
        if (op_reg == ism_pkg::ALU_DIV) begin
            div_sel = quo_reg;
            div_neg = a_reg[ism_pkg::VALUE_W-1] ^ b_reg[ism_pkg::VALUE_W-1];
        end else begin
            div_sel = rem_reg;
            div_neg = a_reg[ism_pkg::VALUE_W-1];
        end
    end

    // Steer the adder operands
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (st_reg)
            A_ADD: begin
                add_x   = (op_reg == ism_pkg::ALU_NEG) ? 33'sd0 : {{2{a_reg[30]}}, a_reg};
                add_y   = {{2{b_reg[30]}}, b_reg};
                add_sub = (op_reg != ism_pkg::ALU_ADD);
            end
            A_DIV: begin
                add_x   = {2'b00, rem_reg, quo_reg[ism_pkg::OPERAND_W-1]};
                add_y   = {3'b000, dvs_reg};
                add_sub = 1'b1;
            end
            A_DIV_SIGN: begin
                add_x   = '0;
                add_y   = {3'b000, div_sel};
                add_sub = div_neg;
            end
            default: begin
            end
        endcase
    end

    // Sequence the operation
    always_comb begin
        st_next   = st_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        iter_next = iter_reg;
        res_next  = res_reg;
        err_next  = err_reg;
        case (st_reg)
            A_IDLE: begin
                if (req.start) begin
                    op_next = req.op;
                    a_next  = req.a;
                    b_next  = req.b;
                    case (req.op)
                        ism_pkg::ALU_MUL: st_next = A_MUL;
                        ism_pkg::ALU_DIV: st_next = A_DIV_INIT;
                        ism_pkg::ALU_MOD: st_next = A_DIV_INIT;
                        default:          st_next = A_ADD;
                    endcase
                end
            end
            A_ADD: begin
                res_next = add_sum[ism_pkg::VALUE_W-1:0];
                err_next = (add_sum > ism_pkg::LIMIT_S33) || (add_sum < ism_pkg::NEG_LIMIT_S33);
                st_next  = A_DONE;
            end
            A_MUL: begin
                prod_next = 62'(a_reg) * 62'(b_reg);
                st_next   = A_MUL_CHK;
            end
            A_MUL_CHK: begin
                res_next = prod_reg[ism_pkg::VALUE_W-1:0];
                err_next = (prod_reg > ism_pkg::LIMIT_S62) || (prod_reg < ism_pkg::NEG_LIMIT_S62);
                st_next  = A_DONE;
            end
            A_DIV_INIT: begin
                // Reject a zero divisor, else load magnitudes
                if (b_reg == '0) begin
                    err_next = 1'b1;
                    st_next  = A_DONE;
                end else begin
                    rem_next  = '0;
                    quo_next  = a_abs[ism_pkg::OPERAND_W-1:0];
                    dvs_next  = b_abs[ism_pkg::OPERAND_W-1:0];
                    iter_next = '0;
                    st_next   = A_DIV;
                end
            end
            A_DIV: begin
                // One restoring step: keep the trial difference if it is not negative
                if (!add_sum[32]) begin
                    rem_next = add_sum[ism_pkg::OPERAND_W-1:0];
                    quo_next = {quo_reg[ism_pkg::OPERAND_W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[ism_pkg::OPERAND_W-2:0], quo_reg[ism_pkg::OPERAND_W-1]};
                    quo_next = {quo_reg[ism_pkg::OPERAND_W-2:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ism_pkg::ITER_W'(ism_pkg::OPERAND_W - 1)) begin
                    st_next = A_DIV_SIGN;
                end
            end
            A_DIV_SIGN: begin
                res_next = add_sum[ism_pkg::VALUE_W-1:0];
                err_next = 1'b0;
                st_next  = A_DONE;
            end
            A_DONE: begin
                st_next = A_IDLE;
            end
            default: begin
                st_next = A_IDLE;
            end
        endcase
        if (st_reg == A_IDLE && req.start) begin
            err_next = 1'b0;
        end
    end

    // Hold state and operands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= A_IDLE;
            err_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            err_reg <= err_next;
        end
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        iter_reg <= iter_next;
        res_reg  <= res_next;
    end

    assign rsp.done   = (st_reg == A_DONE);
    assign rsp.err    = err_reg;
    assign rsp.result = res_reg;

endmodule

// File: design/integer_stack_machine_core.sv
// ----------------------------------------------------------------------------
// integer_stack_machine_core: integer stack program runner
// Takes start, instruction and finish words on the s_ channel and returns
// one result word on the m_ channel for each finish word.
// ----------------------------------------------------------------------------
// Usage:
//   s_data carries mode, opcode and operand. A start word empties the stack,
//   clears the error mark and pushes the operand; an operand above the
//   limit instead leaves the stack empty and sets the error mark.
//   Instruction words work on the stack top; the first failing one sets the
//   error mark and later instructions are dropped until the next start. A
//   finish word returns the single stack value with status 0, or value 0
//   with status 1. One word is in flight at a time; s_ready is high only
//   while idle. DIV and MOD run on the divider in the arithmetic unit, which
//   resolves one quotient bit per cycle over 30 bits; a zero divisor is
//   refused before the divide. A finish word reaches m_valid through an
//   output register. Stack reads go through a registered port.
//   A waiting result sits in an output register, so later non-finish words
//   are still taken while the receiver stalls; a second finish waits for
//   the output register to drain.
//   Reset clears the stack count, the error mark and m_valid; stack memory
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module integer_stack_machine_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ism_pkg::ism_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ism_pkg::ism_out_t m_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH_FIRST,
        S_FETCH_SECOND,
        S_EXEC,
        S_SWAP_LOW,
        S_ALU_WAIT,
        S_REPORT_RD,
        S_REPORT
    } core_state_t;

    core_state_t                        state_reg, state_next;
    ism_pkg::ism_in_t                   item_reg, item_next;
    logic [ism_pkg::CNT_W-1:0]          count_reg, count_next;
    logic                               err_reg, err_next;
    logic signed [ism_pkg::VALUE_W-1:0] first_reg, first_next;
    logic signed [ism_pkg::VALUE_W-1:0] second_reg, second_next;
    logic                               rep_status_reg, rep_status_next;
    logic                               m_valid_reg, m_valid_next;
    ism_pkg::ism_out_t                  m_data_reg, m_data_next;

    ism_pkg::ram_wr_t                   ram_wr;
    logic                               ram_rd_en;
    logic [ism_pkg::ADDR_W-1:0]         ram_rd_addr;
    logic signed [ism_pkg::VALUE_W-1:0] ram_rd_data;
    ism_pkg::alu_req_t                  alu_req;
    ism_pkg::alu_rsp_t                  alu_rsp;

    logic [ism_pkg::CNT_W-1:0]  cnt_m1, cnt_m2;
    logic [ism_pkg::ADDR_W-1:0] top_addr, below_addr, push_addr;
    logic                       stack_full;
    ism_pkg::alu_op_t           bin_op;

    assign cnt_m1     = count_reg - ism_pkg::CNT_W'(1);
    assign cnt_m2     = count_reg - ism_pkg::CNT_W'(2);
    assign top_addr   = cnt_m1[ism_pkg::ADDR_W-1:0];
    assign below_addr = cnt_m2[ism_pkg::ADDR_W-1:0];
    assign push_addr  = count_reg[ism_pkg::ADDR_W-1:0];
    assign stack_full = (count_reg == ism_pkg::CNT_W'(ism_pkg::STACK_DEPTH));

    // Map binary opcodes onto unit operations
    always_comb begin
        case (item_reg.opcode)
            ism_pkg::OP_ADD: bin_op = ism_pkg::ALU_ADD;
            ism_pkg::OP_SUB: bin_op = ism_pkg::ALU_SUB;
            ism_pkg::OP_MUL: bin_op = ism_pkg::ALU_MUL;
            ism_pkg::OP_DIV: bin_op = ism_pkg::ALU_DIV;
            default:         bin_op = ism_pkg::ALU_MOD;
        endcase
    end

    // Sequence one word
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        rep_status_next = rep_status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_wr          = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = top_addr;
        alu_req.start   = 1'b0;
        alu_req.op      = bin_op;
        alu_req.a       = second_reg;
        alu_req.b       = first_reg;

        // Drop the result word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_IDLE;
                case (item_reg.mode)
                    ism_pkg::MODE_START: begin
                        if (item_reg.operand > ism_pkg::LIMIT_U) begin
                            count_next = '0;
                            err_next   = 1'b1;
                        end else begin
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = '0;
                            ram_wr.data = {1'b0, item_reg.operand};
                            count_next  = ism_pkg::CNT_W'(1);
                            err_next    = 1'b0;
                        end
                    end
                    ism_pkg::MODE_EXEC: begin
                        if (!err_reg) begin
                            case (item_reg.opcode)
                                ism_pkg::OP_NUM: begin
                                    if (item_reg.operand > ism_pkg::LIMIT_U || stack_full) begin
                                        err_next = 1'b1;
                                    end else begin
                                        ram_wr.en   = 1'b1;
                                        ram_wr.addr = push_addr;
                                        ram_wr.data = {1'b0, item_reg.operand};
                                        count_next  = count_reg + 1'b1;
                                    end
                                end
                                ism_pkg::OP_POP: begin
                                    if (count_reg == '0) begin
                                        err_next = 1'b1;
                                    end else begin
                                        count_next = cnt_m1;
                                    end
                                end
                                ism_pkg::OP_INV, ism_pkg::OP_DUP: begin
                                    if (count_reg == '0) begin
                                        err_next = 1'b1;
                                    end else begin
                                        ram_rd_en  = 1'b1;
                                        state_next = S_FETCH_FIRST;
                                    end
                                end
                                ism_pkg::OP_SWP, ism_pkg::OP_ADD, ism_pkg::OP_SUB,
                                ism_pkg::OP_MUL, ism_pkg::OP_DIV, ism_pkg::OP_MOD: begin
                                    if (count_reg < ism_pkg::CNT_W'(2)) begin
                                        err_next = 1'b1;
                                    end else begin
                                        ram_rd_en  = 1'b1;
                                        state_next = S_FETCH_FIRST;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    ism_pkg::MODE_FINISH: begin
                        if (err_reg || count_reg != ism_pkg::CNT_W'(1)) begin
                            first_next      = '0;
                            rep_status_next = 1'b1;
                            state_next      = S_REPORT;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            state_next  = S_REPORT_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_FETCH_FIRST: begin
                first_next = ram_rd_data;
                if (item_reg.opcode == ism_pkg::OP_INV || item_reg.opcode == ism_pkg::OP_DUP) begin
                    state_next = S_EXEC;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = below_addr;
                    state_next  = S_FETCH_SECOND;
                end
            end
            S_FETCH_SECOND: begin
                second_next = ram_rd_data;
                state_next  = S_EXEC;
            end
            S_EXEC: begin
                case (item_reg.opcode)
                    ism_pkg::OP_INV: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ism_pkg::ALU_NEG;
                        state_next    = S_ALU_WAIT;
                    end
                    ism_pkg::OP_DUP: begin
                        state_next = S_IDLE;
                        if (stack_full) begin
                            err_next = 1'b1;
                        end else begin
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = push_addr;
                            ram_wr.data = first_reg;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    ism_pkg::OP_SWP: begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = top_addr;
                        ram_wr.data = second_reg;
                        state_next  = S_SWAP_LOW;
                    end
                    default: begin
                        // Pop both operands, the result is pushed later
                        count_next    = cnt_m2;
                        alu_req.start = 1'b1;
                        state_next    = S_ALU_WAIT;
                    end
                endcase
            end
            S_SWAP_LOW: begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = below_addr;
                ram_wr.data = first_reg;
                state_next  = S_IDLE;
            end
            S_ALU_WAIT: begin
                if (alu_rsp.done) begin
                    state_next = S_IDLE;
                    if (alu_rsp.err) begin
                        err_next = 1'b1;
                    end else if (item_reg.opcode == ism_pkg::OP_INV) begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = top_addr;
                        ram_wr.data = alu_rsp.result;
                    end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = push_addr;
                        ram_wr.data = alu_rsp.result;
                        count_next  = count_reg + 1'b1;
                    end
                end
            end
            S_REPORT_RD: begin
                first_next      = ram_rd_data;
                rep_status_next = 1'b0;
                state_next      = S_REPORT;
            end
            S_REPORT: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.result_value = first_reg;
                    m_data_next.status       = rep_status_reg;
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg       <= item_next;
        first_reg      <= first_next;
        second_reg     <= second_next;
        rep_status_reg <= rep_status_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ism_stack u_stack (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ism_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

`ifndef SYNTH
    // Stack count never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ism_pkg::CNT_W'(ism_pkg::STACK_DEPTH))
        else $error("stack count above depth");

    // A start word leaves at most one value on the stack
    a_start_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == ism_pkg::MODE_START) |=> ##1
        (count_reg <= ism_pkg::CNT_W'(1)))
        else $error("start left more than one value");

    // The arithmetic unit finishes only while the sequencer waits for it
    a_alu_done: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> (state_reg == S_ALU_WAIT))
        else $error("arithmetic result with no waiting operation");

    // An error report carries a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.status || m_data.result_value == '0))
        else $error("error report with nonzero value");
`endif

endmodule
